>>> sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion held off while reset is high
`define ASSERT_CLKD(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");

// concurrent assertion that is also checked during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

>>> sv/rsev_pkg.sv
// types, constants and helpers of the rsn element stream validator
`timescale 1ns / 1ps
package rsev_pkg;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SECURITY_MODE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PMF_DEMAND    = 1'd1;

  // security modes
  localparam logic [1:0] MODE_WPA2_PSK = 2'd0;
  localparam logic [1:0] MODE_WPA3_SAE = 2'd1;
  localparam logic [1:0] MODE_MIXED    = 2'd2;

  // verdict codes
  localparam logic [1:0] VERDICT_ACCEPT    = 2'd0;
  localparam logic [1:0] VERDICT_MALFORMED = 2'd1;
  localparam logic [1:0] VERDICT_REFUSED   = 2'd2;

  // element format
  localparam logic [7:0]  RSN_ELEMENT_ID = 8'd48;
  localparam logic [7:0]  RSN_MIN_BODY   = 8'd18;
  localparam logic [7:0]  OUI_BYTE0      = 8'h00;
  localparam logic [7:0]  OUI_BYTE1      = 8'h0f;
  localparam logic [7:0]  OUI_BYTE2      = 8'hac;
  localparam logic [23:0] OUI_PREFIX     = {OUI_BYTE0, OUI_BYTE1, OUI_BYTE2};
  localparam logic [7:0]  RSN_VERSION    = 8'd1;
  localparam logic [7:0]  SUITE_CCMP     = 8'd4;
  localparam logic [7:0]  AKM_PSK        = 8'd2;
  localparam logic [7:0]  AKM_SAE        = 8'd8;
  localparam logic [7:0]  CAP_MFPC       = 8'(1 << 7);

  // found flag bit positions
  localparam int unsigned FL_PCCMP = 0;
  localparam int unsigned FL_PSK   = 1;
  localparam int unsigned FL_SAE   = 2;
  localparam int unsigned FL_MFPC  = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       sae_selected;
  } out_beat_t;

  typedef struct packed {
    logic [1:0] security_mode;
    logic       pmf_demand;
  } cfg_t;

  typedef struct packed {
    logic      push;
    out_beat_t beat;
  } result_t;

  // fixed head of the rsn body: version, group oui and ccmp suite type
  function automatic logic [7:0] head_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = RSN_VERSION;
      3'd1:    v = 8'd0;
      3'd2:    v = OUI_BYTE0;
      3'd3:    v = OUI_BYTE1;
      3'd4:    v = OUI_BYTE2;
      3'd5:    v = SUITE_CCMP;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/rsev_out_buf.sv
// output register with a skid stage for the verdict channel
`timescale 1ns / 1ps
module rsev_out_buf
  import rsev_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  result_t   res,
  output logic      can_take,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic      main_valid;
  logic      skid_valid;
  out_beat_t main_beat;
  out_beat_t skid_beat;

  assign can_take  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_ready) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= res.push;
      end
    end else if (res.push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || out_ready) begin
      if (skid_valid) begin
        main_beat <= skid_beat;
      end else if (res.push) begin
        main_beat <= res.beat;
      end
    end else if (res.push) begin
      skid_beat <= res.beat;
    end
  end

endmodule

>>> sv/rsev_parser.sv
// per-byte walk of the element list and rsn body checks, verdict on buffer end
`timescale 1ns / 1ps
module rsev_parser
  import rsev_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_beat_t beat,
  input  cfg_t     cfg,
  output result_t  res
);

  typedef enum logic [3:0] {
    PH_TYPE, PH_LEN_OTHER, PH_LEN_RSN, PH_SKIP, PH_HEAD, PH_PCOUNT, PH_PSUITE,
    PH_ACOUNT, PH_ASUITE, PH_CAP, PH_TAIL, PH_DRAIN, PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  elem_left, elem_left_next;
  logic [7:0]  body_len, body_len_next;
  logic [7:0]  rsn_pos, rsn_pos_next;
  logic [15:0] suites_left, suites_left_next;
  logic [23:0] suite_bytes, suite_bytes_next;
  logic [3:0]  flags, flags_next;
  logic [1:0]  pending, pending_next;

  logic [7:0]  b;
  logic [7:0]  pos_inc;
  logic [7:0]  room;
  logic [15:0] count;
  logic        ends;
  logic [1:0]  verdict;
  logic        sae;
  logic        psk_seen;
  logic        sae_seen;
  logic        bad;

  assign b       = beat.data_byte;
  assign pos_inc = rsn_pos + 8'd1;
  assign room    = body_len - pos_inc;
  assign count   = {b, suite_bytes[7:0]};
  assign ends    = !beat.has_byte || beat.is_last;

  always_comb begin
    phase_next       = phase;
    elem_left_next   = elem_left;
    body_len_next    = body_len;
    rsn_pos_next     = rsn_pos;
    suites_left_next = suites_left;
    suite_bytes_next = suite_bytes;
    flags_next       = flags;
    pending_next     = pending;
    if (beat.has_byte) begin
      case (phase)
        PH_TYPE: begin
          phase_next = (b == RSN_ELEMENT_ID) ? PH_LEN_RSN : PH_LEN_OTHER;
        end
        PH_LEN_OTHER: begin
          elem_left_next = b;
          phase_next     = (b != 8'd0) ? PH_SKIP : PH_TYPE;
        end
        PH_LEN_RSN: begin
          body_len_next  = b;
          rsn_pos_next   = 8'd0;
          elem_left_next = 8'd0;
          flags_next     = '0;
          if (b == 8'd0) begin
            pending_next = VERDICT_REFUSED;
            phase_next   = PH_DONE;
          end else if (b < RSN_MIN_BODY) begin
            pending_next = VERDICT_REFUSED;
            phase_next   = PH_DRAIN;
          end else begin
            phase_next = PH_HEAD;
          end
        end
        PH_SKIP: begin
          elem_left_next = elem_left - 8'd1;
          if (elem_left == 8'd1) begin
            phase_next = PH_TYPE;
          end
        end
        PH_DONE: begin
        end
        default: begin
          // inside the rsn body
          rsn_pos_next = pos_inc;
          case (phase)
            PH_HEAD: begin
              if (rsn_pos >= 8'd6 || b != head_byte(rsn_pos[2:0])) begin
                pending_next = VERDICT_REFUSED;
                phase_next   = PH_DRAIN;
              end else if (rsn_pos == 8'd5) begin
                phase_next = PH_PCOUNT;
              end
            end
            PH_PCOUNT, PH_ACOUNT: begin
              if (elem_left == 8'd0) begin
                suite_bytes_next = {16'd0, b};
                elem_left_next   = 8'd1;
              end else begin
                elem_left_next   = 8'd0;
                suite_bytes_next = '0;
                if (count == 16'd0 || count > {10'd0, room[7:2]}) begin
                  pending_next = VERDICT_MALFORMED;
                  phase_next   = PH_DRAIN;
                end else begin
                  suites_left_next = count;
                  phase_next = (phase == PH_PCOUNT) ? PH_PSUITE : PH_ASUITE;
                end
              end
            end
            PH_PSUITE, PH_ASUITE: begin
              if (elem_left < 8'd3) begin
                suite_bytes_next = {suite_bytes[15:0], b};
                elem_left_next   = elem_left + 8'd1;
              end else begin
                if (suite_bytes == OUI_PREFIX) begin
                  if (phase == PH_PSUITE) begin
                    if (b == SUITE_CCMP) flags_next[FL_PCCMP] = 1'b1;
                  end else if (b == AKM_PSK) begin
                    flags_next[FL_PSK] = 1'b1;
                  end else if (b == AKM_SAE) begin
                    flags_next[FL_SAE] = 1'b1;
                  end
                end
                elem_left_next   = 8'd0;
                suite_bytes_next = '0;
                suites_left_next = suites_left - 16'd1;
                if (suites_left == 16'd1) begin
                  if (phase == PH_PSUITE) begin
                    if (room < 8'd2) begin
                      pending_next = VERDICT_MALFORMED;
                      phase_next   = PH_DRAIN;
                    end else begin
                      phase_next = PH_ACOUNT;
                    end
                  end else begin
                    phase_next = (room >= 8'd2) ? PH_CAP : PH_TAIL;
                  end
                end
              end
            end
            PH_CAP: begin
              if ((b & CAP_MFPC) != 8'd0) flags_next[FL_MFPC] = 1'b1;
              phase_next = PH_TAIL;
            end
            default: begin
            end
          endcase
          if (pos_inc == body_len) begin
            if (phase_next != PH_DRAIN) pending_next = VERDICT_ACCEPT;
            phase_next = PH_DONE;
          end
        end
      endcase
    end
  end

  // verdict from the state the current byte leaves behind
  always_comb begin
    psk_seen = flags_next[FL_PSK];
    sae_seen = flags_next[FL_SAE];
    if (phase_next == PH_TYPE) begin
      verdict = VERDICT_REFUSED;
    end else if (phase_next != PH_DONE) begin
      verdict = VERDICT_MALFORMED;
    end else begin
      verdict = pending_next;
    end
    bad = !flags_next[FL_PCCMP] ||
          (cfg.security_mode == MODE_WPA2_PSK && !psk_seen) ||
          (cfg.security_mode == MODE_WPA3_SAE && !sae_seen) ||
          (cfg.security_mode == MODE_MIXED && !psk_seen && !sae_seen) ||
          (cfg.pmf_demand && !flags_next[FL_MFPC]);
    sae = 1'b0;
    if (verdict == VERDICT_ACCEPT) begin
      if (bad) begin
        verdict = VERDICT_REFUSED;
      end else begin
        sae = sae_seen && (cfg.security_mode == MODE_WPA3_SAE || !psk_seen);
      end
    end
    if (cfg.security_mode != MODE_WPA2_PSK && cfg.security_mode != MODE_WPA3_SAE &&
        cfg.security_mode != MODE_MIXED) begin
      verdict = VERDICT_REFUSED;
      sae     = 1'b0;
    end
  end

  assign res.push              = accept && ends;
  assign res.beat.verdict      = verdict;
  assign res.beat.sae_selected = sae;

  always_ff @(posedge clk) begin
    if (rst || (accept && ends)) begin
      phase       <= PH_TYPE;
      elem_left   <= '0;
      body_len    <= '0;
      rsn_pos     <= '0;
      suites_left <= '0;
      suite_bytes <= '0;
      flags       <= '0;
      pending     <= VERDICT_REFUSED;
    end else if (accept) begin
      phase       <= phase_next;
      elem_left   <= elem_left_next;
      body_len    <= body_len_next;
      rsn_pos     <= rsn_pos_next;
      suites_left <= suites_left_next;
      suite_bytes <= suite_bytes_next;
      flags       <= flags_next;
      pending     <= pending_next;
    end
  end

endmodule

>>> sv/rsn_element_stream_validator_top.sv
// top level of the rsn element stream validator
// one byte beat is taken every cycle while input ready is high; the verdict of the beat
// that ends the buffer (has_byte low or is_last high) goes to the output or skid register
// throughput is set by the per-byte parse registers: one byte per clock while input ready is high
// input ready drops only while the output register and its skid stage both hold beats
// synchronous reset clears the parse state, the output stages and both config registers
`timescale 1ns / 1ps
module rsn_element_stream_validator_top
  import rsev_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_beat_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_beat_t              out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  result_t res;
  logic    accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SECURITY_MODE: cfg.security_mode <= cfg_data;
        REG_PMF_DEMAND:    cfg.pmf_demand    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign accept = in_valid && in_ready;

  rsev_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .beat   (in_data),
    .cfg    (cfg),
    .res    (res)
  );

  rsev_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .can_take  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> sv/rsev_checker.sv
// port-level checks of the validator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rsev_checker
  import rsev_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  logic ends_beat;
  logic stalled;
  logic sae_flagged;

  assign ends_beat   = in_valid && in_ready && (!in_data.has_byte || in_data.is_last);
  assign stalled     = out_valid && !out_ready;
  assign sae_flagged = out_valid && out_data.sae_selected;

  // a held verdict beat stays put
  `ASSERT_CLKD(a_out_hold, clk, rst, stalled |=> out_valid && $stable(out_data))
  // sae is only reported with an accepted verdict
  `ASSERT_CLKD(a_sae_accept, clk, rst, sae_flagged |-> (out_data.verdict == VERDICT_ACCEPT))
  // no verdict code beyond refused
  `ASSERT_CLKD(a_verdict_range, clk, rst, out_valid |-> (out_data.verdict != 2'd3))
  // output is empty right after reset
  `ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !out_valid)
  // a second verdict under a stalled one fills the skid stage and closes input
  `ASSERT_CLKD(a_skid_full, clk, rst, (stalled && ends_beat) |=> !in_ready)

endmodule

bind rsn_element_stream_validator_top rsev_checker u_rsev_checker (.*);
